### rtl/uled_pkg.sv
`default_nettype none

package uled_pkg;

  localparam int unsigned CmdLen      = 8;
  localparam int unsigned PosW        = $clog2(CmdLen);
  localparam int unsigned HalfW       = 15;
  localparam int unsigned CountW      = 16;

  localparam logic [HalfW-1:0] HALF_PERIOD_RESET = 15'd500;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] ALL_LEDS = 8'hFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CmdLen-1:0][7:0] cmd_buf;
    logic [PosW-1:0]        byte_pos;
    logic [7:0]             led_latch;
    logic                   blink_active;
    logic [7:0]             blink_mask;
    logic [CountW-1:0]      period_count;
  } state_t;

  function automatic logic [7:0] digit_bit(logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ONE;
    if (c >= CH_ONE && c <= CH_EIGHT) begin
      return 8'(8'd1 << d[2:0]);
    end
    return 8'd0;
  endfunction

  function automatic state_t decode(state_t s, logic allow_blink);
    state_t r;
    logic [CmdLen-1:0][7:0] b;
    logic [7:0] m;
    r = s;
    b = s.cmd_buf;
    m = 8'd0;
    if (b[0] == CH_O && b[1] == CH_N && b[2] == CH_ZERO && b[4] == CH_HASH) begin
      r.led_latch = r.led_latch | digit_bit(b[3]);
    end
    if (b[0] == CH_O && b[1] == CH_N && b[2] == CH_STAR && b[3] == CH_HASH) begin
      r.led_latch = ALL_LEDS;
    end
    if (b[0] == CH_O && b[1] == CH_F && b[2] == CH_F && b[3] == CH_ZERO &&
        b[5] == CH_HASH) begin
      r.led_latch = r.led_latch & ~digit_bit(b[4]);
    end
    if (b[0] == CH_O && b[1] == CH_F && b[2] == CH_F && b[3] == CH_STAR &&
        b[4] == CH_HASH) begin
      r.led_latch = 8'd0;
    end
    if (allow_blink) begin
      if (b[0] == CH_B && b[1] == CH_L && b[2] == CH_I && b[3] == CH_N &&
          b[4] == CH_K && b[5] == CH_ZERO && b[7] == CH_HASH) begin
        m = digit_bit(b[6]);
      end
      if (b[0] == CH_B && b[1] == CH_L && b[2] == CH_I && b[3] == CH_N &&
          b[4] == CH_K && b[5] == CH_STAR && b[6] == CH_HASH) begin
        m = ALL_LEDS;
      end
      if (m != 8'd0) begin
        r.blink_mask   = m;
        r.blink_active = 1'b1;
        r.period_count = '0;
        r.led_latch    = r.led_latch | m;
      end
    end
    return r;
  endfunction

  function automatic logic terminated(logic [CmdLen-1:0][7:0] b);
    return (b[4] == CH_HASH) ||
           (b[2] == CH_STAR && b[3] == CH_HASH) ||
           (b[5] == CH_HASH) ||
           (b[3] == CH_STAR && b[4] == CH_HASH) ||
           (b[5] == CH_STAR && b[6] == CH_HASH);
  endfunction

endpackage

`default_nettype wire

### rtl/uled_step.sv
`default_nettype none

module uled_step (
  input  var uled_pkg::state_t             state_cur,
  input  var uled_pkg::opcode_t            opcode,
  input  var logic [7:0]                   rx_byte,
  input  var logic [uled_pkg::HalfW-1:0]   half_period,
  output uled_pkg::state_t                 state_nxt
);

  uled_pkg::state_t                       byte_st;
  uled_pkg::state_t                       tick_st;
  logic [uled_pkg::CmdLen-1:0][7:0]       nbuf;
  logic [uled_pkg::CountW-1:0]            half;
  logic [uled_pkg::CountW-1:0]            twice;
  logic [uled_pkg::CountW:0]              cnt;
  logic                                   last_pos;

  always_comb begin
    for (int i = 0; i < uled_pkg::CmdLen; i++) begin
      if (uled_pkg::PosW'(i) == state_cur.byte_pos) begin
        nbuf[i] = rx_byte;
      end else if (state_cur.byte_pos == '0) begin
        nbuf[i] = 8'd0;
      end else begin
        nbuf[i] = state_cur.cmd_buf[i];
      end
    end
    last_pos = (state_cur.byte_pos == uled_pkg::PosW'(uled_pkg::CmdLen - 1));
    byte_st = state_cur;
    byte_st.cmd_buf = nbuf;
    if (last_pos || uled_pkg::terminated(nbuf)) begin
      byte_st.byte_pos = '0;
      byte_st = uled_pkg::decode(byte_st, !state_cur.blink_active);
    end else begin
      byte_st.byte_pos = state_cur.byte_pos + 1'b1;
    end
  end

  always_comb begin
    half  = (half_period == '0) ? uled_pkg::CountW'(1)
                                : uled_pkg::CountW'(half_period);
    twice = {half[uled_pkg::CountW-2:0], 1'b0};
    cnt   = {1'b0, state_cur.period_count} + 1'b1;
    tick_st = state_cur;
    if (state_cur.byte_pos == '0 && state_cur.blink_active) begin
      if (cnt >= {1'b0, twice}) begin
        tick_st.period_count = twice;
        tick_st.blink_active = 1'b0;
        tick_st = uled_pkg::decode(tick_st, 1'b1);
      end else begin
        tick_st.period_count = cnt[uled_pkg::CountW-1:0];
        if (cnt >= {1'b0, half}) begin
          tick_st.led_latch = state_cur.led_latch & ~state_cur.blink_mask;
        end else begin
          tick_st.led_latch = state_cur.led_latch | state_cur.blink_mask;
        end
      end
    end
  end

  assign state_nxt = (opcode == uled_pkg::OP_BYTE) ? byte_st : tick_st;

endmodule

`default_nettype wire

### rtl/uart_led_command_decoder_core.sv
`default_nettype none

// LED command decoder. Each input transaction is a received ASCII byte or a
// one-millisecond tick, and each yields exactly one result transaction with
// the LED pattern, the receiving flag and the blinking flag after that item.
// Commands ON0d#, OFF0d#, ON*#, OFF*#, BLINK0d# and BLINK*# are collected in
// an eight-byte buffer; half_period_ticks sets the blink on and off time.
// An item is taken into an input register, and the decode logic writes the
// result register from it, so one item per clock is sustained while out_stall
// does not hold a waiting result. While a result waits under out_stall, the
// input register takes one more item if it is empty and then stalls the
// input. Write cfg_half_period_ticks only while no transaction is in flight;
// cfg_ready is always high.

module uart_led_command_decoder_core (
  input  var logic                        clk,
  input  var logic                        rst_n,
  input  var logic                        in_valid,
  output logic                            in_stall,
  input  var logic                        in_opcode,
  input  var logic [7:0]                  in_rx_byte,
  output logic                            out_valid,
  input  var logic                        out_stall,
  output logic [7:0]                      out_led_pattern,
  output logic                            out_receiving,
  output logic                            out_blinking,
  input  var logic                        cfg_valid,
  output logic                            cfg_ready,
  input  var logic [uled_pkg::HalfW-1:0]  cfg_half_period_ticks
);

  logic                          in_valid_r;
  uled_pkg::opcode_t             in_opcode_r;
  logic [7:0]                    in_rx_byte_r;
  logic                          out_valid_r;
  logic [7:0]                    out_led_pattern_r;
  logic                          out_receiving_r;
  logic                          out_blinking_r;
  logic [uled_pkg::HalfW-1:0]    half_period_r;
  uled_pkg::state_t              state_r;
  uled_pkg::state_t              state_nxt;
  logic                          advance;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  uled_step u_step (
    .state_cur   (state_r),
    .opcode      (in_opcode_r),
    .rx_byte     (in_rx_byte_r),
    .half_period (half_period_r),
    .state_nxt   (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= uled_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_half_period_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_opcode_r  <= uled_pkg::opcode_t'(in_opcode);
      in_rx_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_led_pattern_r <= state_nxt.led_latch;
      out_receiving_r   <= (state_nxt.byte_pos != '0);
      out_blinking_r    <= state_nxt.blink_active;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_led_pattern_r;
  assign out_receiving   = out_receiving_r;
  assign out_blinking    = out_blinking_r;

endmodule

`default_nettype wire

### dv/tb_uart_led_command_decoder_core.sv
`default_nettype none

module tb_uart_led_command_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] leds;
    logic       rx_busy;
    logic       blink;
  } led_status_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_opcode;
  logic [7:0]                    in_rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_led_pattern;
  logic                          out_receiving;
  logic                          out_blinking;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [uled_pkg::HalfW-1:0]    cfg_half_period_ticks;

  // predicted block state
  logic [7:0]                    cmd_bytes [0:uled_pkg::CmdLen-1];
  logic [uled_pkg::PosW-1:0]     cmd_pos;
  logic [7:0]                    led_state;
  logic                          blink_run;
  logic [7:0]                    blink_leds;
  logic [uled_pkg::CountW-1:0]   blink_count;
  logic [uled_pkg::HalfW-1:0]    half_ticks;

  led_status_t         status_q [$];
  led_status_t         oldest_status;
  logic [7:0]          cmd_seq [$];
  int unsigned         items_sent;
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  int unsigned         send_idle;
  int unsigned         recv_stall;
  int unsigned         hold_left;

  uart_led_command_decoder_core i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_led_pattern       (out_led_pattern),
    .out_receiving         (out_receiving),
    .out_blinking          (out_blinking),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_half_period_ticks (cfg_half_period_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] led_of_digit(logic [7:0] c);
    if (c >= uled_pkg::CH_ONE && c <= uled_pkg::CH_EIGHT) begin
      return 8'd1 << 3'(c - uled_pkg::CH_ONE);
    end
    return 8'd0;
  endfunction

  function automatic bit cmd_starts(string pat);
    for (int i = 0; i < pat.len(); i++) begin
      if (cmd_bytes[i] != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit cmd_complete();
    return (cmd_bytes[4] == uled_pkg::CH_HASH) ||
           (cmd_bytes[2] == uled_pkg::CH_STAR && cmd_bytes[3] == uled_pkg::CH_HASH) ||
           (cmd_bytes[5] == uled_pkg::CH_HASH) ||
           (cmd_bytes[3] == uled_pkg::CH_STAR && cmd_bytes[4] == uled_pkg::CH_HASH) ||
           (cmd_bytes[5] == uled_pkg::CH_STAR && cmd_bytes[6] == uled_pkg::CH_HASH);
  endfunction

  function automatic void apply_command(bit allow_blink);
    logic [7:0] sel;
    sel = 8'd0;
    if (cmd_starts("ON0") && cmd_bytes[4] == uled_pkg::CH_HASH)
      led_state |= led_of_digit(cmd_bytes[3]);
    if (cmd_starts("ON*#")) led_state = uled_pkg::ALL_LEDS;
    if (cmd_starts("OFF0") && cmd_bytes[5] == uled_pkg::CH_HASH)
      led_state &= ~led_of_digit(cmd_bytes[4]);
    if (cmd_starts("OFF*#")) led_state = 8'd0;
    if (allow_blink) begin
      if (cmd_starts("BLINK0") && cmd_bytes[7] == uled_pkg::CH_HASH)
        sel = led_of_digit(cmd_bytes[6]);
      if (cmd_starts("BLINK*#")) sel = uled_pkg::ALL_LEDS;
      if (sel != 8'd0) begin
        blink_leds  = sel;
        blink_run   = 1'b1;
        blink_count = '0;
        led_state  |= sel;
      end
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    if (cmd_pos == 0) begin
      foreach (cmd_bytes[i]) cmd_bytes[i] = 8'd0;
    end
    cmd_bytes[cmd_pos] = b;
    if (cmd_pos == uled_pkg::PosW'(uled_pkg::CmdLen - 1) || cmd_complete()) begin
      cmd_pos = '0;
      apply_command(!blink_run);
    end else begin
      cmd_pos = cmd_pos + 1'b1;
    end
  endfunction

  function automatic void predict_tick();
    int unsigned half;
    int unsigned cnt;
    if (cmd_pos != 0 || !blink_run) return;
    half = (half_ticks == 0) ? 1 : half_ticks;
    cnt  = blink_count + 1;
    if (cnt >= 2 * half) begin
      blink_count = uled_pkg::CountW'(2 * half);
      blink_run   = 1'b0;
      apply_command(1'b1);
    end else begin
      blink_count = uled_pkg::CountW'(cnt);
      if (cnt >= half) led_state &= ~blink_leds;
      else led_state |= blink_leds;
    end
  endfunction

  task automatic send_item(input uled_pkg::opcode_t op, input logic [7:0] b);
    led_status_t st;
    while ($urandom_range(99) < send_idle) begin
      in_valid   <= 1'b0;
      in_opcode  <= 1'($urandom_range(1));
      in_rx_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == uled_pkg::OP_BYTE) predict_byte(b);
    else predict_tick();
    st.leds    = led_state;
    st.rx_busy = (cmd_pos != 0);
    st.blink   = blink_run;
    status_q.push_back(st);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(uled_pkg::OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(uled_pkg::OP_BYTE, s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [uled_pkg::HalfW-1:0] half);
    cfg_valid             <= 1'b1;
    cfg_half_period_ticks <= half;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    half_ticks  = half;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) cmd_seq.push_back(s[i]);
  endfunction

  task automatic send_random_command();
    int unsigned kind;
    int unsigned half;
    logic [7:0]  d;
    logic [7:0]  fill;
    // realign to the start of a command
    while (cmd_pos != 0) begin
      fill = 8'($urandom_range(255));
      if (fill == uled_pkg::CH_HASH) fill = uled_pkg::CH_STAR;
      send_item(uled_pkg::OP_BYTE, fill);
    end
    case ($urandom_range(3))
      0: d = uled_pkg::CH_ZERO;
      1: d = 8'h39;
      default: d = uled_pkg::CH_ONE + 8'($urandom_range(7));
    endcase
    if ($urandom_range(3) != 0) d = uled_pkg::CH_ONE + 8'($urandom_range(7));
    if ($urandom_range(19) == 0) d = 8'($urandom_range(255));
    cmd_seq.delete();
    kind = $urandom_range(99);
    if (kind < 18) begin
      add_text("ON0");
      cmd_seq.push_back(d);
      add_text("#");
    end else if (kind < 36) begin
      add_text("OFF0");
      cmd_seq.push_back(d);
      add_text("#");
    end else if (kind < 44) begin
      add_text("ON*#");
    end else if (kind < 52) begin
      add_text("OFF*#");
    end else if (kind < 70) begin
      add_text("BLINK0");
      cmd_seq.push_back(d);
      add_text("#");
    end else if (kind < 80) begin
      add_text("BLINK*#");
    end else if (kind < 90) begin
      add_text("BLINK0");
      cmd_seq.push_back(d);
      add_text("#");
      cmd_seq[$urandom_range(cmd_seq.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(1) == 0) void'(cmd_seq.pop_back());
    end else begin
      repeat ($urandom_range(1, 8)) cmd_seq.push_back(8'($urandom_range(255)));
    end
    foreach (cmd_seq[i]) begin
      if ($urandom_range(99) < 4) send_ticks(1);
      send_item(uled_pkg::OP_BYTE, cmd_seq[i]);
    end
    half = (half_ticks == 0) ? 1 : half_ticks;
    if (blink_run) send_ticks($urandom_range(1, 2 * half + 3));
    else send_ticks($urandom_range(2));
  endtask

  task automatic test_led_commands();
    send_idle  = 0;
    recv_stall = 0;
    send_ticks(1);
    send_text("ON*#");
    send_text("OFF0");
    send_ticks(1);
    send_text("8#");
    send_text("OFF*#");
    send_text("ON01#");
    send_text("ON09#");
    send_text("OFF00#");
    repeat (8) send_item(uled_pkg::OP_BYTE, 8'hFF);
    repeat (8) send_item(uled_pkg::OP_BYTE, 8'h00);
  endtask

  task automatic test_period_change();
    send_text("BLINK*#");
    send_ticks(4);
    drain_results();
    write_half_period(15'd2);
    send_ticks(6);
    send_text("ON*#");
    send_ticks(4);
  endtask

  task automatic test_blink_rules();
    drain_results();
    write_half_period(15'd1);
    send_text("BLINK03#");
    send_ticks(1);
    send_text("ON02#");
    send_ticks(2);
    send_text("BLINK05#");
    send_ticks(1);
    send_text("BLINK*#");
    send_ticks(3);
    send_text("OFF*#");
    send_ticks(3);
  endtask

  task automatic test_longest_period();
    drain_results();
    write_half_period(15'h7FFF);
    send_text("BLINK08#");
    send_ticks(10);
    drain_results();
    write_half_period(15'd3);
    send_ticks(2);
    send_text("OFF08#");
    send_ticks(7);
  endtask

  task automatic test_backpressure();
    drain_results();
    write_half_period(15'd2);
    send_idle  = 0;
    recv_stall = 0;
    hold_left  = 300;
    repeat (40) send_random_command();
    drain_results();
  endtask

  task automatic run_random_phase(input int unsigned s_idle, input int unsigned r_stall,
                                  input logic [uled_pkg::HalfW-1:0] half,
                                  input int unsigned n);
    int unsigned start;
    drain_results();
    write_half_period(half);
    send_idle  = s_idle;
    recv_stall = r_stall;
    start      = items_sent;
    while (items_sent - start < n / 2) send_random_command();
    drain_results();
    while (items_sent - start < n) send_random_command();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 15'd1, 350);
    run_random_phase(70, 0, 15'd3, 350);
    run_random_phase(0, 70, 15'd7, 350);
    run_random_phase(27, 27, uled_pkg::HalfW'($urandom_range(2, 12)), 350);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        oldest_status = status_q.pop_front();
        if (out_led_pattern !== oldest_status.leds) begin
          $error("led_pattern: expected %02h, got %02h", oldest_status.leds, out_led_pattern);
          mismatch_count++;
        end
        if (out_receiving !== oldest_status.rx_busy) begin
          $error("receiving: expected %0b, got %0b", oldest_status.rx_busy, out_receiving);
          mismatch_count++;
        end
        if (out_blinking !== oldest_status.blink) begin
          $error("blinking: expected %0b, got %0b", oldest_status.blink, out_blinking);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_uart_led_command_decoder_core: done, errors");
    $finish;
  end

  initial begin
    foreach (cmd_bytes[i]) cmd_bytes[i] = 8'd0;
    cmd_pos        = '0;
    led_state      = 8'd0;
    blink_run      = 1'b0;
    blink_leds     = 8'd0;
    blink_count    = '0;
    half_ticks     = uled_pkg::HALF_PERIOD_RESET;
    items_sent     = 0;
    mismatch_count = 0;
    send_idle      = 0;
    recv_stall     = 0;
    hold_left      = 0;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_opcode             <= uled_pkg::OP_BYTE;
    in_rx_byte            <= 8'd0;
    cfg_valid             <= 1'b0;
    cfg_half_period_ticks <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_led_commands();
    test_period_change();
    test_blink_rules();
    test_longest_period();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_uart_led_command_decoder_core: done, clean");
    end else begin
      $display("tb_uart_led_command_decoder_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### uart_led_command_decoder_core.f
rtl/uled_pkg.sv
rtl/uled_step.sv
rtl/uart_led_command_decoder_core.sv
dv/tb_uart_led_command_decoder_core.sv
